@@ rtl/core/bdhr_pkg.sv @@
// Package for the button debouncer with long-press and auto-repeat.
// Holds widths, register indexes, reset values and shared types.
// No dependencies.
package bdhr_pkg;

  localparam int unsigned CountWidth  = 16;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CmpWidth    = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;

  localparam logic [CfgIdxWidth-1:0] CfgIdxDebounce = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgIdxHold     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgIdxRepeat   = 2'd2;

  localparam logic [CfgWidth-1:0] DebounceReset = 16'd1;
  localparam logic [CfgWidth-1:0] HoldReset     = 16'd20;
  localparam logic [CfgWidth-1:0] RepeatReset   = 16'd3;

  typedef enum logic [1:0] {
    LvlReleased = 2'd0,
    LvlPressed  = 2'd1,
    LvlHeld     = 2'd2
  } level_e;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_ticks;
    logic [CfgWidth-1:0] hold_ticks;
    logic [CfgWidth-1:0] rpt_ticks;
  } cfg_t;

  typedef struct packed {
    logic   event_res;
    level_e level;
  } result_t;

endpackage

@@ rtl/core/bdhr_core.sv @@
// Debounce, long-press and repeat state; one tick per cycle in which step_i is high.
// Holds the level, pending-change marker and tick counter; uses bdhr_pkg.
module bdhr_core import bdhr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    pressed_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  typedef enum logic [1:0] {
    PendNone    = 2'd0,
    PendPress   = 2'd1,
    PendRelease = 2'd2
  } pend_e;

  level_e                level_q, level_d;
  pend_e                 pend_q, pend_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  logic [CountWidth-1:0] cnt_inc, cnt_tmp;
  logic [CfgWidth-1:0]   limit;
  logic                  evt;

  // The counter saturates rather than wrapping.
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
  assign limit   = (level_q == LvlPressed) ? cfg_i.hold_ticks : cfg_i.rpt_ticks;

  always_comb begin
    level_d = level_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    cnt_tmp = cnt_q;
    evt     = 1'b0;
    if (pend_q != PendNone) begin
      if ((pend_q == PendPress && pressed_i) || (pend_q == PendRelease && !pressed_i)) begin
        cnt_tmp = cnt_inc;
      end else begin
        pend_d  = pressed_i ? PendPress : PendRelease;
        cnt_tmp = '0;
      end
      // A debounce tick never advances hold or repeat counting.
      if (CmpWidth'(cnt_tmp) >= CmpWidth'(cfg_i.debounce_ticks)) begin
        pend_d  = PendNone;
        cnt_tmp = '0;
        if (level_q == LvlReleased && pressed_i) begin
          level_d = LvlPressed;
          evt     = 1'b1;
        end else if (level_q != LvlReleased && !pressed_i) begin
          level_d = LvlReleased;
        end
      end
      cnt_d = cnt_tmp;
    end else begin
      case (level_q)
        LvlReleased: begin
          if (pressed_i) pend_d = PendPress;
        end
        LvlPressed, LvlHeld: begin
          if (!pressed_i) begin
            pend_d = PendRelease;
            cnt_d  = '0;
          end else if (CmpWidth'(cnt_inc) >= CmpWidth'(limit)) begin
            cnt_d   = '0;
            level_d = LvlHeld;
            evt     = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= LvlReleased;
      pend_q  <= PendNone;
      cnt_q   <= '0;
    end else if (step_i) begin
      level_q <= level_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
    end
  end

  assign res_o.event_res = evt;
  assign res_o.level     = level_d;

  a_evt_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt |-> (level_d == LvlPressed || level_d == LvlHeld))
    else $error("event raised without a pressed or held level");

  a_idle_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (level_q == LvlReleased && pend_q == PendNone) |-> (cnt_q == '0))
    else $error("tick counter not clear while released and idle");

  a_hold_evt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && level_q == LvlPressed && level_d == LvlHeld) |-> evt)
    else $error("entered held level without an event");

endmodule

@@ rtl/core/button_debounce_hold_repeat.sv @@
// Results are registered in the output register, or in the skid register during a stall.
// Throughput: one item per cycle while the skid register is empty; a two-entry result
// buffer (output plus skid register) keeps input ready while one result waits for the consumer.
// Reset: asynchronous, active low; level released, nothing pending, counter zero,
// registers at debounce 1, hold 20, repeat 3. Configuration writes take effect next cycle.
// Top level: config registers, bdhr_core and the result buffer; uses bdhr_pkg.
module button_debounce_hold_repeat import bdhr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]    cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   pressed_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   event_res_o,
  output logic [1:0]             level_o
);

  cfg_t    cfg_q;
  result_t res;
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;
  logic    push, pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= DebounceReset;
      cfg_q.hold_ticks     <= HoldReset;
      cfg_q.rpt_ticks      <= RepeatReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgIdxDebounce: cfg_q.debounce_ticks <= cfg_data_i;
        CfgIdxHold:     cfg_q.hold_ticks     <= cfg_data_i;
        CfgIdxRepeat:   cfg_q.rpt_ticks      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  bdhr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (push),
    .pressed_i (pressed_i),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = out_q.event_res;
  assign level_o     = out_q.level;

  a_skid_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result ahead of an empty output register");

  a_stall_store : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !out_ready_i) |=> skid_valid_q)
    else $error("transfer during an output stall was not kept");

endmodule
